### hw/rtl/button_press_duration_classifier_macros.svh
// assertion macros of the button press duration classifier rtl
`ifndef BUTTON_PRESS_DURATION_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_DURATION_CLASSIFIER_MACROS_SVH

// same-cycle implication, checked outside reset
`define BPDC_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("bpdc assertion failed");

// next-cycle implication, checked outside reset
`define BPDC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("bpdc assertion failed");

`endif

### hw/rtl/bpdc_pkg.sv
// types, constants and helpers of the button press duration classifier
`default_nettype none

package bpdc_pkg;

   // width of the wrapping microsecond time base
   localparam int TIME_BITS    = 40;
   localparam int NOW_BITS     = 40;
   localparam int CMD_BITS     = 2;
   localparam int STATUS_BITS  = 3;
   localparam int MS_BITS      = 16;
   // a 16-bit millisecond value times 1000 fits in 26 bits
   localparam int US_BITS      = MS_BITS + 10;
   localparam int CSR_IDX_BITS = 8;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_PRESS   = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_QUERY   = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_NOTHING    = 3'd0,
      ST_START      = 3'd1,
      ST_STOP       = 3'd2,
      ST_TEST       = 3'd3,
      ST_BOOT_READY = 3'd4,
      ST_BOOTLOADER = 3'd5
   } status_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_START_MS     = 8'd0,
      REG_ABORT_MS     = 8'd1,
      REG_SELF_TEST_MS = 8'd2,
      REG_UPDATE_MS    = 8'd3
   } reg_idx_type;

   localparam logic [MS_BITS-1:0] START_MS_RST     = 16'd100;
   localparam logic [MS_BITS-1:0] ABORT_MS_RST     = 16'd3000;
   localparam logic [MS_BITS-1:0] SELF_TEST_MS_RST = 16'd5000;
   localparam logic [MS_BITS-1:0] UPDATE_MS_RST    = 16'd10000;

   // milliseconds to microseconds: x*1000 = x*1024 - x*16 - x*8
   function automatic logic [US_BITS-1:0] ms_to_us(input logic [MS_BITS-1:0] ms);
      logic [US_BITS-1:0] wide;
      wide     = US_BITS'(ms);
      ms_to_us = (wide << 10) - (wide << 4) - (wide << 3);
   endfunction

endpackage

`default_nettype wire

### hw/rtl/bpdc_if.sv
// valid/ready channel interfaces of the button press duration classifier
`default_nettype none

// event and query transactions
interface bpdc_req_if;
   logic                            valid;
   logic                            ready;
   logic [bpdc_pkg::CMD_BITS-1:0]   command;
   logic [bpdc_pkg::NOW_BITS-1:0]   now_us;

   modport source (output valid, output command, output now_us, input ready);
   modport sink   (input valid, input command, input now_us, output ready);
endinterface

// status report transactions
interface bpdc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [bpdc_pkg::STATUS_BITS-1:0]  status;
   logic                              idle;

   modport source (output valid, output status, output idle, input ready);
   modport sink   (input valid, input status, input idle, output ready);
endinterface

// register write transactions
interface bpdc_csr_if;
   logic                               valid;
   logic                               ready;
   logic [bpdc_pkg::CSR_IDX_BITS-1:0]  index;
   logic [bpdc_pkg::MS_BITS-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/button_press_duration_classifier.sv
// Button press duration classifier. Press and release edges and status queries
// arrive as req transactions carrying a 40-bit wrapping microsecond time. A
// transaction is registered on entry and processed against the press state
// from that input register; a status query then places its report in the rsp
// output register, where the report waits until it is taken. One transaction
// is accepted every cycle, limited only by a report that is still waiting in
// the rsp register when the next query needs it. Press and release edges, and
// unknown commands, give no report. Thresholds are written in milliseconds on
// the csr port (index 0 start, 1 abort, 2 self-test, 3 update; other indexes
// are ignored) and are held as microsecond values; write them only while no
// transaction is in flight. No clearing pass is needed after reset.
`default_nettype none

`include "button_press_duration_classifier_macros.svh"

module button_press_duration_classifier (
   input  wire logic   clock,
   input  wire logic   reset,
   bpdc_req_if.sink    req,
   bpdc_rsp_if.source  rsp,
   bpdc_csr_if.sink    csr
);

   localparam int TB = bpdc_pkg::TIME_BITS;
   localparam int UB = bpdc_pkg::US_BITS;

   // thresholds in microseconds
   logic [UB-1:0] start_us_ff, abort_us_ff, self_test_us_ff, update_us_ff;

   // input register
   logic                  s1_valid_ff;
   bpdc_pkg::cmd_type     s1_cmd_ff;
   logic [TB-1:0]         s1_time_ff;
   logic                  s1_adv;

   // press state
   logic                  press_held_ff, press_held_in;
   logic [TB-1:0]         press_time_ff, press_time_in;
   logic                  update_armed_ff, update_armed_in;
   bpdc_pkg::status_type  status_ff, status_in;

   // output register
   logic                  rsp_valid_ff;
   bpdc_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic                  rsp_idle_ff, rsp_idle_in;
   logic                  s1_is_query;

   logic [TB-1:0]         held_us;

   // register writes, always taken
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_us_ff     <= bpdc_pkg::ms_to_us(bpdc_pkg::START_MS_RST);
         abort_us_ff     <= bpdc_pkg::ms_to_us(bpdc_pkg::ABORT_MS_RST);
         self_test_us_ff <= bpdc_pkg::ms_to_us(bpdc_pkg::SELF_TEST_MS_RST);
         update_us_ff    <= bpdc_pkg::ms_to_us(bpdc_pkg::UPDATE_MS_RST);
      end else if (csr.valid) begin
         case (csr.index)
            bpdc_pkg::REG_START_MS:     start_us_ff     <= bpdc_pkg::ms_to_us(csr.data);
            bpdc_pkg::REG_ABORT_MS:     abort_us_ff     <= bpdc_pkg::ms_to_us(csr.data);
            bpdc_pkg::REG_SELF_TEST_MS: self_test_us_ff <= bpdc_pkg::ms_to_us(csr.data);
            bpdc_pkg::REG_UPDATE_MS:    update_us_ff    <= bpdc_pkg::ms_to_us(csr.data);
            default: ;
         endcase
      end
   end

   // stage flow: only a query needs room in the output register
   assign s1_is_query = (s1_cmd_ff == bpdc_pkg::CMD_QUERY);
   assign s1_adv      = s1_valid_ff && (!s1_is_query || !rsp_valid_ff || rsp.ready);
   assign req.ready   = !s1_valid_ff || s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         s1_cmd_ff  <= bpdc_pkg::cmd_type'(req.command);
         s1_time_ff <= TB'(req.now_us);
      end
   end

   // held interval, modulo the time base
   assign held_us = s1_time_ff - press_time_ff;

   // next press state and report
   always_comb begin
      press_held_in   = press_held_ff;
      press_time_in   = press_time_ff;
      update_armed_in = update_armed_ff;
      status_in       = status_ff;
      rsp_status_in   = status_ff;
      rsp_idle_in     = 1'b0;
      case (s1_cmd_ff)
         bpdc_pkg::CMD_PRESS: begin
            press_time_in = s1_time_ff;
            press_held_in = 1'b1;
         end
         bpdc_pkg::CMD_RELEASE: begin
            if (press_held_ff) begin
               if (update_armed_ff) begin
                  status_in       = bpdc_pkg::ST_BOOTLOADER;
                  update_armed_in = 1'b0;
               end
               if (held_us > TB'(start_us_ff) && held_us < TB'(abort_us_ff)) begin
                  status_in = bpdc_pkg::ST_START;
               end
               if (held_us > TB'(self_test_us_ff) && held_us < TB'(update_us_ff)) begin
                  status_in = bpdc_pkg::ST_TEST;
               end
               press_held_in = 1'b0;
            end
         end
         bpdc_pkg::CMD_QUERY: begin
            if (press_held_ff) begin
               if (held_us > TB'(abort_us_ff)) begin
                  status_in = bpdc_pkg::ST_STOP;
               end
               if (held_us > TB'(update_us_ff) && !update_armed_ff) begin
                  update_armed_in = 1'b1;
                  status_in       = bpdc_pkg::ST_BOOT_READY;
               end
            end
            rsp_status_in = status_in;
            rsp_idle_in   = !press_held_ff && (status_in == bpdc_pkg::ST_NOTHING);
            // a report with no press held clears the status
            if (!press_held_ff) begin
               status_in = bpdc_pkg::ST_NOTHING;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_held_ff   <= 1'b0;
         press_time_ff   <= '0;
         update_armed_ff <= 1'b0;
         status_ff       <= bpdc_pkg::ST_NOTHING;
      end else if (s1_adv) begin
         press_held_ff   <= press_held_in;
         press_time_ff   <= press_time_in;
         update_armed_ff <= update_armed_in;
         status_ff       <= status_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_is_query) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_is_query) begin
         rsp_status_ff <= rsp_status_in;
         rsp_idle_ff   <= rsp_idle_in;
      end
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.status = rsp_status_ff;
   assign rsp.idle   = rsp_idle_ff;

   // checks
   `BPDC_ASSERT_NOW(a_idle_means_nothing, clock, reset, rsp_valid_ff && rsp_idle_ff, rsp_status_ff == bpdc_pkg::ST_NOTHING)
   `BPDC_ASSERT_NOW(a_arm_only_while_held, clock, reset, $rose(update_armed_ff), press_held_ff)
   `BPDC_ASSERT_NEXT(a_query_gives_report, clock, reset, s1_adv && s1_is_query, rsp_valid_ff)
   `BPDC_ASSERT_NOW(a_stalled_stage_blocks_input, clock, reset, s1_valid_ff && !s1_adv, !req.ready)

endmodule

`default_nettype wire
